[hdl/tap_pkg.sv]
// ----------------------------------------------------------------------------
// tap_pkg: shared types and constants for the tensor axis permute block
// Register indexes, field widths and the operation codes.
// ----------------------------------------------------------------------------
package tap_pkg;
  localparam int unsigned MaxAxes    = 4;
  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned AddrW      = 12;
  localparam int unsigned DimW       = 13;
  localparam int unsigned IdxW       = 12;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 52;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AXIS_COUNT = 3'd0,
    REG_AXIS_ORDER = 3'd1,
    REG_OUT_DIMS   = 3'd2,
    REG_SRC_STRIDE = 3'd3,
    REG_DST_STRIDE = 3'd4,
    REG_ELEM_COUNT = 3'd5
  } cfg_reg_e;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;
endpackage

[hdl/tensor_axis_permute.sv]
// ----------------------------------------------------------------------------
// tensor_axis_permute: N-d tensor axis permutation over a source word store
// Loads write the store; emits split a linear index into coordinates and
// return the destination address and the source word.
// ----------------------------------------------------------------------------
// channel  | dir | contents
// s_axis   | in  | tuser operation; tdata load_addr, load_data, out_index
// m_axis   | out | tuser range_error; tdata dst_addr, src_addr, elem_data
// cfg      | in  | register index, write data
//
// A load goes through S_WR. An emit runs, for up to 4 axes, a restoring
// divider (13 quotient bits, then one accumulate step), then S_CHK, S_RD and
// S_OUT; a range error skips the divider or S_RD. Reset clears control state
// only; the store needs no clearing. A stalled result holds the output
// register, and no new item is taken until the last is done and taken.
module tensor_axis_permute
  import tap_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [55:0]         s_axis_tdata,  // load_addr, load_data, out_index
  input  logic                s_axis_tuser,  // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [55:0]         m_axis_tdata,  // dst_addr, src_addr, elem_data
  output logic                m_axis_tuser,  // range_error
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;

  logic [2:0]          axis_count_q;
  logic [7:0]          axis_order_q;
  logic [CfgDataW-1:0] out_dims_q, src_str_q, dst_str_q;
  logic [DimW-1:0]     elem_count_q;

  logic [2:0]      state_q, state_d;
  logic [2:0]      axis_q;
  logic [3:0]      bit_q;
  logic [DimW-1:0] quot_q, rem_q;
  logic [27:0]     dst_full_q, src_full_q;
  logic [AddrW-1:0] ld_addr_q;
  logic [DataWidth-1:0] ld_data_q;
  logic            err_q;
  logic [AddrW-1:0] dst_o_q, src_o_q;
  logic [DataWidth-1:0] dat_o_q;
  logic            oval_q;

  logic [1:0]      ax;
  logic [DimW-1:0] size, dstr, sstr;
  logic [1:0]      sax;
  logic [DimW:0]   trial;
  logic [DimW-1:0] nrem;
  logic [2*DimW-1:0] dprod, sprod;
  logic            ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [DataWidth-1:0] ram_rdata;
  logic [2:0]      naxes;

  assign ax   = axis_q[1:0] - 2'd1;
  assign size = (out_dims_q[ax*DimW +: DimW] == '0) ? DimW'(1) : out_dims_q[ax*DimW +: DimW];
  assign sax  = axis_order_q[ax*2 +: 2];
  assign dstr = dst_str_q[ax*DimW +: DimW];
  assign sstr = src_str_q[sax*DimW +: DimW];
  assign trial = {rem_q, quot_q[DimW-1]};
  assign nrem  = (trial >= {1'b0, size}) ? DimW'(trial - {1'b0, size}) : trial[DimW-1:0];
  assign dprod = rem_q * dstr;
  assign sprod = rem_q * sstr;
  assign naxes = (axis_count_q > 3'(MaxAxes)) ? 3'(MaxAxes) : axis_count_q;

  assign s_axis_tready = (state_q == S_IDLE) && !oval_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = {dat_o_q, src_o_q, dst_o_q};
  assign m_axis_tuser  = err_q;

  assign ram_we   = (state_q == S_WR);
  assign ram_addr = (state_q == S_WR) ? ld_addr_q : src_full_q[AddrW-1:0];

  tap_ram #(.Width(DataWidth), .Depth(StoreDepth)) u_store (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ld_data_q), .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_count_q <= 3'd4;
      axis_order_q <= 8'd228;
      out_dims_q   <= '0;
      src_str_q    <= '0;
      dst_str_q    <= '0;
      elem_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_AXIS_COUNT: axis_count_q <= cfg_data_i[2:0];
        REG_AXIS_ORDER: axis_order_q <= cfg_data_i[7:0];
        REG_OUT_DIMS:   out_dims_q   <= cfg_data_i;
        REG_SRC_STRIDE: src_str_q    <= cfg_data_i;
        REG_DST_STRIDE: dst_str_q    <= cfg_data_i;
        REG_ELEM_COUNT: elem_count_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_LOAD) begin
          state_d = S_WR;
        end else if ({1'b0, s_axis_tdata[55:44]} >= elem_count_q || naxes == 3'd0) begin
          state_d = S_CHK;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: if (bit_q == 4'd0) state_d = S_ACC;
      S_ACC: state_d = (axis_q == 3'd1) ? S_CHK : S_DIV;
      S_CHK: state_d = err_q ? S_OUT : ((dst_full_q >= 28'(StoreDepth) ||
                                         src_full_q >= 28'(StoreDepth)) ? S_OUT : S_RD);
      S_RD:  state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      S_WR:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (oval_q && m_axis_tready) oval_q <= 1'b0;
      case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready)
          err_q <= {1'b0, s_axis_tdata[55:44]} >= elem_count_q;
        S_CHK: if (dst_full_q >= 28'(StoreDepth) || src_full_q >= 28'(StoreDepth))
          err_q <= 1'b1;
        S_OUT: oval_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ld_addr_q  <= s_axis_tdata[AddrW-1:0];
        ld_data_q  <= s_axis_tdata[AddrW +: DataWidth];
        quot_q     <= {1'b0, s_axis_tdata[55:44]};
        rem_q      <= '0;
        axis_q     <= naxes;
        bit_q      <= 4'(DimW - 1);
        dst_full_q <= '0;
        src_full_q <= '0;
      end
      S_DIV: begin
        rem_q  <= nrem;
        quot_q <= {quot_q[DimW-2:0], (trial >= {1'b0, size})};
        bit_q  <= bit_q - 4'd1;
      end
      S_ACC: begin
        dst_full_q <= dst_full_q + 28'(dprod);
        src_full_q <= src_full_q + 28'(sprod);
        rem_q      <= '0;
        axis_q     <= axis_q - 3'd1;
        bit_q      <= 4'(DimW - 1);
      end
      S_OUT: begin
        dst_o_q <= err_q ? '0 : dst_full_q[AddrW-1:0];
        src_o_q <= err_q ? '0 : src_full_q[AddrW-1:0];
        dat_o_q <= err_q ? '0 : ram_rdata;
      end
      default: ;
    endcase
  end
endmodule

[hdl/tap_ram.sv]
// ----------------------------------------------------------------------------
// tap_ram: generic single-port RAM
// One access per cycle, read data registered; a write cycle also reads the old word.
// ----------------------------------------------------------------------------
module tap_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

[hdl/tap_checker.sv]
// ----------------------------------------------------------------------------
// tap_checker: port-level checks for tensor_axis_permute
// Watches the stream channels over time.
// ----------------------------------------------------------------------------
module tap_checker
  import tap_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result carries data");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken with result pending");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back-to-back transfer accepted");
endmodule

bind tensor_axis_permute tap_checker u_tap_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
